// ===== hw/rtl/power_hold_sequencer_top_assert.svh =====
`ifndef POWER_HOLD_SEQUENCER_TOP_ASSERT_SVH
`define POWER_HOLD_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/phs_pkg.sv =====
package phs_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    PH_ON       = 2'd0,
    PH_WAITING  = 2'd1,
    PH_SHUTTING = 2'd2,
    PH_OFF      = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAIT_TIMEOUT     = 2'd0,
    REG_SHUTDOWN_TIMEOUT = 2'd1,
    REG_RESTART_TIMEOUT  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] wait_ms;
    logic [TimeW-1:0] shutdown_ms;
    logic [TimeW-1:0] restart_ms;
  } timeouts_t;

  typedef struct packed {
    phase_e phase;
    logic   load_stamp;
  } step_t;

endpackage

// ===== hw/rtl/phs_step.sv =====
module phs_step (
  input  phs_pkg::phase_e                 phase_i,
  input  logic [phs_pkg::TimeW-1:0]       now_ms_i,
  input  logic                            key_present_i,
  input  logic [phs_pkg::TimeW-1:0]       stamp_i,
  input  phs_pkg::timeouts_t              timeouts_i,
  output phs_pkg::step_t                  step_o
);
  import phs_pkg::*;

  logic [TimeW-1:0] timeout;
  logic [TimeW-1:0] limit;
  logic             expired;

  // one shared stamp: only the timeout of the current phase matters
  always_comb begin
    unique case (phase_i)
      PH_WAITING:  timeout = timeouts_i.wait_ms;
      PH_SHUTTING: timeout = timeouts_i.shutdown_ms;
      default:     timeout = timeouts_i.restart_ms;
    endcase
  end

  // sum wraps mod 2^32 before the compare
  assign limit   = stamp_i + timeout;
  assign expired = now_ms_i > limit;

  always_comb begin
    step_o.phase      = phase_i;
    step_o.load_stamp = 1'b0;
    unique case (phase_i)
      PH_ON: begin
        if (!key_present_i) begin
          step_o.phase      = PH_WAITING;
          step_o.load_stamp = 1'b1;
        end
      end
      PH_WAITING: begin
        priority if (key_present_i) begin
          step_o.phase = PH_ON;
        end else if (expired) begin
          step_o.phase      = PH_SHUTTING;
          step_o.load_stamp = 1'b1;
        end else begin
          // still waiting
          step_o.phase = PH_WAITING;
        end
      end
      PH_SHUTTING: begin
        if (expired) begin
          step_o.phase      = PH_OFF;
          step_o.load_stamp = 1'b1;
        end
      end
      PH_OFF: begin
        if (expired && key_present_i) begin
          step_o.phase = PH_ON;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/power_hold_sequencer_top.sv =====
// A word passes the input register, then the result register, to the master side.
// One word moves per cycle while the master side takes results; each register
// holds one word, and the path between them is one 32-bit add and compare. Reset
// (rst_ni low, asynchronous): phase returns to on, timeouts clear to zero, both
// stages empty. The stamp is not reset; waiting, shutting, off load it on entry.
`include "power_hold_sequencer_top_assert.svh"

module power_hold_sequencer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [phs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [phs_pkg::TimeW-1:0]        cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [phs_pkg::InDataW-1:0]      s_axis_tdata,  // [31:0] now_ms, [32] key_present
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [phs_pkg::OutDataW-1:0]     m_axis_tdata   // [0] keep_power, [2:1] phase
);
  import phs_pkg::*;

  timeouts_t        timeouts_q;
  phase_e           phase_q;
  logic [TimeW-1:0] stamp_q;

  logic             in_valid_q;
  logic [TimeW-1:0] now_q;
  logic             key_q;

  logic             out_valid_q;
  logic             keep_power_q;
  phase_e           out_phase_q;

  logic             advance;
  step_t            step;

  // the input stage moves on whenever the result register is free or draining
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  phs_step u_step (
    .phase_i       (phase_q),
    .now_ms_i      (now_q),
    .key_present_i (key_q),
    .stamp_i       (stamp_q),
    .timeouts_i    (timeouts_q),
    .step_o        (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeouts_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WAIT_TIMEOUT:     timeouts_q.wait_ms     <= cfg_data_i;
        REG_SHUTDOWN_TIMEOUT: timeouts_q.shutdown_ms <= cfg_data_i;
        REG_RESTART_TIMEOUT:  timeouts_q.restart_ms  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_ON;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (advance && in_valid_q) begin
        phase_q <= step.phase;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      now_q <= s_axis_tdata[TimeW-1:0];
      key_q <= s_axis_tdata[TimeW];
    end
    if (advance && in_valid_q) begin
      keep_power_q <= step.phase != PH_OFF;
      out_phase_q  <= step.phase;
      if (step.load_stamp) begin
        stamp_q <= now_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 3){1'b0}}, out_phase_q, keep_power_q};

  `PHS_ASSERT_NOW(a_keep_power_matches_phase, out_valid_q,
    keep_power_q == (out_phase_q != PH_OFF), "keep_power disagrees with phase")
  `PHS_ASSERT_NEXT(a_stage_moves, advance && in_valid_q,
    out_valid_q && (out_phase_q == phase_q), "result does not follow the processed word")
  `PHS_ASSERT_NEXT(a_on_exits_to_waiting, phase_q == PH_ON,
    phase_q == PH_ON || phase_q == PH_WAITING, "on phase left other than to waiting")
  `PHS_ASSERT_NEXT(a_shutting_exits_to_off, phase_q == PH_SHUTTING,
    phase_q == PH_SHUTTING || phase_q == PH_OFF, "shutting phase left other than to off")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import phs_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIdxW-1:0] RegIdxUnused = 2'd3;

  typedef struct packed {
    logic   keep_power;
    phase_e phase;
  } power_state_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [TimeW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  power_hold_sequencer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sequencer shadow state
  phase_e           seq_phase = PH_ON;
  logic [TimeW-1:0] wait_stamp, shut_stamp, off_stamp;
  logic [TimeW-1:0] wait_span = '0;
  logic [TimeW-1:0] shut_span = '0;
  logic [TimeW-1:0] restart_span = '0;

  power_state_t     pending_states[$];
  power_state_t     want_state;
  int unsigned      mismatches = 0;
  int unsigned      cycle_count = 0;
  int unsigned      send_idle_pct = 27;
  int unsigned      recv_idle_pct = 66;
  logic [TimeW-1:0] drive_ms;
  logic             key_held;

  function automatic logic span_elapsed(input logic [TimeW-1:0] now_ms,
                                        input logic [TimeW-1:0] stamp,
                                        input logic [TimeW-1:0] span);
    logic [TimeW-1:0] deadline;
    deadline = stamp + span;  // wraps mod 2^32 on purpose
    return now_ms > deadline;
  endfunction

  function automatic void advance_phase(input logic [TimeW-1:0] now_ms, input logic key);
    case (seq_phase)
      PH_ON: begin
        if (!key) begin
          wait_stamp = now_ms;
          seq_phase = PH_WAITING;
        end
      end
      PH_WAITING: begin
        if (key) begin
          seq_phase = PH_ON;
        end else if (span_elapsed(now_ms, wait_stamp, wait_span)) begin
          shut_stamp = now_ms;
          seq_phase = PH_SHUTTING;
        end
      end
      PH_SHUTTING: begin
        if (span_elapsed(now_ms, shut_stamp, shut_span)) begin
          off_stamp = now_ms;
          seq_phase = PH_OFF;
        end
      end
      default: begin
        if (key && span_elapsed(now_ms, off_stamp, restart_span)) begin
          seq_phase = PH_ON;
        end
      end
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [TimeW-1:0] now_ms, input logic key);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {7'b0, key, now_ms};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_phase(now_ms, key);
    pending_states.push_back('{keep_power: (seq_phase != PH_OFF), phase: seq_phase});
    @(negedge clk_i);
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid = 1'b0;
    while (pending_states.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_WAIT_TIMEOUT:     wait_span = value;
      REG_SHUTDOWN_TIMEOUT: shut_span = value;
      REG_RESTART_TIMEOUT:  restart_span = value;
      default: ;
    endcase
  endtask

  function automatic logic [TimeW-1:0] pick_timeout();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
      3:       return $urandom;
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  // walk through every phase with all timeouts at their reset value of zero
  task automatic test_reset_timeouts();
    send_word(32'd100, 1'b1);
    send_word(32'd100, 1'b0);
    send_word(32'd100, 1'b0);
    send_word(32'd101, 1'b1);
    send_word(32'd200, 1'b0);
    send_word(32'd201, 1'b0);
    send_word(32'd201, 1'b1);  // key is ignored while shutting
    send_word(32'd202, 1'b1);
    send_word(32'd202, 1'b1);
    send_word(32'd203, 1'b0);
    send_word(32'd203, 1'b1);
    wait_for_idle();
  endtask

  // deadlines that wrap early and deadlines parked near all ones
  task automatic test_timeout_wrap();
    write_reg(REG_WAIT_TIMEOUT, 32'hFFFF_FFF0);
    write_reg(REG_SHUTDOWN_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_RESTART_TIMEOUT, 32'h0000_0010);
    write_reg(RegIdxUnused, 32'hFFFF_FFFF);
    send_word(32'h20, 1'b0);
    send_word(32'h20, 1'b0);
    send_word(32'h20, 1'b1);
    send_word(32'h30, 1'b1);
    send_word(32'h31, 1'b1);
    wait_for_idle();
    write_reg(REG_WAIT_TIMEOUT, 32'h10);
    send_word(32'hFFFF_FFE0, 1'b0);
    send_word(32'hFFFF_FFF0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h10, 1'b1);
    wait_for_idle();
  endtask

  // drive sessions: a slowly advancing clock with runs of key on/off, some jumps
  task automatic test_random_traffic(input int unsigned words, input logic near_wrap);
    int unsigned max_step;
    write_reg(REG_WAIT_TIMEOUT, pick_timeout());
    write_reg(REG_SHUTDOWN_TIMEOUT, pick_timeout());
    write_reg(REG_RESTART_TIMEOUT, pick_timeout());
    write_reg(RegIdxUnused, $urandom);
    max_step = near_wrap ? 3 : 6;
    drive_ms = near_wrap ? (32'hFFFF_FFFF - $urandom_range(0, 300)) : $urandom;
    key_held = 1'($urandom_range(1));
    for (int unsigned i = 0; i < words; i++) begin
      if ($urandom_range(99) < 4) begin
        drive_ms = $urandom;
        send_word(drive_ms, 1'($urandom_range(1)));
      end else begin
        drive_ms += $urandom_range(0, max_step);
        if ($urandom_range(99) < 15) key_held = ~key_held;
        send_word(drive_ms, key_held);
      end
    end
    wait_for_idle();
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_states.size() == 0) begin
        $error("result word 0x%0h with no prediction pending", m_axis_tdata);
        mismatches++;
      end else begin
        want_state = pending_states.pop_front();
        if (m_axis_tdata[0] !== want_state.keep_power) begin
          $error("keep_power: expected %0b, got %0b", want_state.keep_power, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[2:1] !== want_state.phase) begin
          $error("phase: expected %0d, got %0d", want_state.phase, m_axis_tdata[2:1]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 66;
    test_reset_timeouts();
    test_timeout_wrap();
    test_random_traffic(108, 1'b0);
    test_random_traffic(108, 1'b1);

    send_idle_pct = 66;
    recv_idle_pct = 27;
    test_random_traffic(108, 1'b0);
    test_random_traffic(108, 1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(108, 1'b1);
    test_random_traffic(110, 1'b0);

    wait_for_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
